// File: hw/rtl/txcon_pkg.sv
// Shared types, character codes and the control store of the text console cursor engine.
`default_nettype none

package txcon_pkg;

  // Character codes handled by the console
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_BLANK    = 8'h20;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  // Item operation selector
  typedef enum logic [1:0] {
    OP_CHAR      = 2'd0,
    OP_RD_SCREEN = 2'd1,
    OP_RD_LINE   = 2'd2
  } op_t;

  // Sequencer steps, one control word each
  typedef enum logic [3:0] {
    ST_CLEAR    = 4'd0,
    ST_IDLE     = 4'd1,
    ST_DECODE   = 4'd2,
    ST_CHAR     = 4'd3,
    ST_NEWLINE  = 4'd4,
    ST_COPY_RD  = 4'd5,
    ST_COPY_WR  = 4'd6,
    ST_ROW_LIM  = 4'd7,
    ST_ROW_CLR  = 4'd8,
    ST_EMIT     = 4'd9
  } step_t;

  // Datapath actions
  typedef enum logic [3:0] {
    A_NOP      = 4'd0,
    A_CLR_CELL = 4'd1,
    A_TAKE     = 4'd2,
    A_DECODE   = 4'd3,
    A_CHAR     = 4'd4,
    A_NEWLINE  = 4'd5,
    A_COPY_RD  = 4'd6,
    A_COPY_WR  = 4'd7,
    A_ROW_LIM  = 4'd8,
    A_EMIT     = 4'd9
  } act_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_MORE      = 3'd2,
    C_NOT_CHAR  = 3'd3,
    C_NO_NL     = 3'd4,
    C_NO_SCROLL = 3'd5
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t tgt;
  } ucode_t;

  // Control store: jump to tgt when cond holds, else fall to the next step
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    unique case (s)
      ST_CLEAR:   w = '{act: A_CLR_CELL, cond: C_MORE,      tgt: ST_CLEAR};
      ST_IDLE:    w = '{act: A_TAKE,     cond: C_NEVER,     tgt: ST_IDLE};
      ST_DECODE:  w = '{act: A_DECODE,   cond: C_NOT_CHAR,  tgt: ST_EMIT};
      ST_CHAR:    w = '{act: A_CHAR,     cond: C_NO_NL,     tgt: ST_EMIT};
      ST_NEWLINE: w = '{act: A_NEWLINE,  cond: C_NO_SCROLL, tgt: ST_EMIT};
      ST_COPY_RD: w = '{act: A_COPY_RD,  cond: C_NEVER,     tgt: ST_IDLE};
      ST_COPY_WR: w = '{act: A_COPY_WR,  cond: C_MORE,      tgt: ST_COPY_RD};
      ST_ROW_LIM: w = '{act: A_ROW_LIM,  cond: C_NEVER,     tgt: ST_IDLE};
      ST_ROW_CLR: w = '{act: A_CLR_CELL, cond: C_MORE,      tgt: ST_ROW_CLR};
      ST_EMIT:    w = '{act: A_EMIT,     cond: C_ALWAYS,    tgt: ST_IDLE};
      default:    w = '{act: A_NOP,      cond: C_ALWAYS,    tgt: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/txcon_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module txcon_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/text_console_cursor_engine_core.sv
// Top level of the text console cursor engine: microcoded sequencer, screen and line RAMs.
//
// Channel  Dir  Handshake                 Word contents
// in       in   in_tvalid / in_tready     tdata: char_code, read_addr; tuser: op, from_keyboard
// out      out  out_tvalid / out_tready   tdata: cursor_addr, line_length, read_data, flags
// cfg      in   cfg_valid / cfg_ready     data: border_rows
//
// A character item runs IDLE, DECODE, CHAR, NEWLINE (on a new line only) and EMIT; reads run
// IDLE, DECODE, EMIT. A scroll copies W*(H-2b-1) cells by a read and a write step each through
// the single screen RAM port pair, then clears the last row; W x H screen, b = border.
// After reset a clearing pass writes zero to all W*H cells, one per cycle; no item is
// taken meanwhile, configuration writes are. Reset is synchronous, active low.
// A finished word waits in the output register; the next item is accepted meanwhile.
`default_nettype none

module text_console_cursor_engine_core #(
  parameter int SCREEN_WIDTH  = 40,
  parameter int SCREEN_HEIGHT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_data,     // border_rows
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [23:0] in_tdata,     // [7:0] char_code, [18:8] read_addr, zero fill
  input  wire logic [2:0]  in_tuser,     // [1:0] op, [2] from_keyboard
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata     // [10:0] cursor_addr, [16:11] line_length,
                                         // [24:17] read_data, [25] scrolled,
                                         // [26] line_committed, zero fill
);

  import txcon_pkg::*;

  localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int CAW    = $clog2(CELLS);
  localparam int XW     = (CAW > 11) ? CAW : 11;
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT + 1);
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int LCW    = $clog2(SCREEN_WIDTH + 1);
  localparam int LAW    = $clog2(SCREEN_WIDTH);
  localparam int BMAX_R = (SCREEN_HEIGHT - 2) / 2;
  localparam int BMAX_C = (SCREEN_WIDTH - 2) / 2;
  localparam int BMAX   = (BMAX_R < BMAX_C) ? BMAX_R : BMAX_C;
  localparam int RST_B  = (BMAX < 1) ? BMAX : 1;

  // Sequencer
  step_t  pc_r, pc_nxt;
  ucode_t cw;
  logic   stall, jump;

  // Configuration and cursor state
  logic [2:0]       border_r;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [LCW-1:0]   count_r, count_nxt;
  logic             pend_r, pend_nxt;
  logic             scrolled_r, scrolled_nxt;
  logic             commit_r, commit_nxt;
  logic [CAW-1:0]   ptr_r, ptr_nxt;
  logic [CAW-1:0]   lim_r, lim_nxt;

  // Current item
  logic [1:0]  op_r;
  logic [7:0]  char_r;
  logic        key_r;
  logic [10:0] addr_r;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [10:0] out_cursor_r;
  logic [5:0]  out_len_r;
  logic [7:0]  out_data_r;
  logic        out_scrolled_r;
  logic        out_commit_r;

  // RAM ports
  logic           scr_we, scr_re;
  logic [CAW-1:0] scr_waddr, scr_raddr;
  logic [7:0]     scr_wdata, scr_rdata;
  logic           lb_we, lb_re;
  logic [LAW-1:0] lb_waddr, lb_raddr;
  logic [7:0]     lb_wdata, lb_rdata;

  // Derived values
  logic [2:0]       b_eff;
  logic [ROW_W-1:0] last_row;
  logic [COL_W-1:0] col_b;
  logic [COL_W:0]   col_inc, right_lim;
  logic             wrap, nl_print, bs_ok;
  logic             is_print, is_cr, is_bs, nl_need;
  logic [CAW-1:0]   cell_addr;
  logic [XW-1:0]    addr_x, cur_x;
  logic             scr_in_range, lb_in_range;
  logic [LCW-1:0]   count_eff;
  logic [7:0]       read_val;

  txcon_ram #(.WIDTH(8), .DEPTH(CELLS)) u_screen (
    .clk   (clk),
    .we    (scr_we),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .re    (scr_re),
    .raddr (scr_raddr),
    .rdata (scr_rdata)
  );

  txcon_ram #(.WIDTH(8), .DEPTH(SCREEN_WIDTH)) u_line (
    .clk   (clk),
    .we    (lb_we),
    .waddr (lb_waddr),
    .wdata (lb_wdata),
    .re    (lb_re),
    .raddr (lb_raddr),
    .rdata (lb_rdata)
  );

  // Fetch the control word of the current step
  assign cw = ucode_rom(pc_r);

  // Clip the border so that one usable row and column remain
  assign b_eff    = (int'(border_r) > BMAX) ? 3'(BMAX) : border_r;
  assign col_b    = COL_W'(b_eff);
  assign last_row = ROW_W'(SCREEN_HEIGHT - 1) - ROW_W'(b_eff);

  // Classify the character
  assign is_print = (char_r >= CH_PRINT_LO) && (char_r <= CH_PRINT_HI);
  assign is_cr    = (char_r == CH_CR);
  assign is_bs    = (char_r == CH_BS);

  // Cursor arithmetic
  assign cell_addr = CAW'(row_r) * CAW'(SCREEN_WIDTH) + CAW'(col_r);
  assign wrap      = (col_r == COL_W'(SCREEN_WIDTH - 1));
  assign col_inc   = {1'b0, col_r} + (COL_W+1)'(1);
  assign right_lim = (COL_W+1)'(SCREEN_WIDTH) - (COL_W+1)'(b_eff);
  assign nl_print  = wrap ? (row_r == ROW_W'(SCREEN_HEIGHT - 1)) : (col_inc >= right_lim);
  assign bs_ok     = {1'b0, col_r} > ((COL_W+1)'(b_eff) + (COL_W+1)'(1));
  assign nl_need   = (is_print && nl_print) || is_cr;

  // Drop a committed line on the first keyboard byte after the commit
  assign count_eff = (key_r && pend_r) ? '0 : count_r;

  // Read ranges and result byte
  assign addr_x       = XW'(addr_r);
  assign scr_in_range = addr_x < XW'(CELLS);
  assign lb_in_range  = addr_r < 11'(count_r);
  assign cur_x        = XW'(cell_addr);

  always_comb begin
    read_val = '0;
    if (op_r == OP_RD_SCREEN && scr_in_range) begin
      read_val = scr_rdata;
    end else if (op_r == OP_RD_LINE && lb_in_range) begin
      read_val = lb_rdata;
    end
  end

  // Hold the step while waiting on either channel
  assign stall = ((cw.act == A_TAKE) && !in_tvalid) ||
                 ((cw.act == A_EMIT) && out_valid_r && !out_tready);

  // Next step
  always_comb begin
    unique case (cw.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_MORE:      jump = (ptr_r != lim_r);
      C_NOT_CHAR:  jump = (op_r != OP_CHAR);
      C_NO_NL:     jump = !nl_need;
      C_NO_SCROLL: jump = (row_r < last_row);
      default:     jump = 1'b1;
    endcase
    if (stall) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = cw.tgt;
    end else begin
      pc_nxt = step_t'(pc_r + 4'd1);
    end
  end

  // Datapath controls and register updates per action
  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    count_nxt     = count_r;
    pend_nxt      = pend_r;
    scrolled_nxt  = scrolled_r;
    commit_nxt    = commit_r;
    ptr_nxt       = ptr_r;
    lim_nxt       = lim_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    scr_we        = 1'b0;
    scr_waddr     = ptr_r;
    scr_wdata     = '0;
    scr_re        = 1'b0;
    scr_raddr     = addr_x[CAW-1:0];
    lb_we         = 1'b0;
    lb_waddr      = count_eff[LAW-1:0];
    lb_wdata      = char_r;
    lb_re         = 1'b0;
    lb_raddr      = addr_r[LAW-1:0];
    unique case (cw.act)
      A_NOP: begin
      end
      A_CLR_CELL: begin
        scr_we  = 1'b1;
        ptr_nxt = ptr_r + CAW'(1);
      end
      A_TAKE: begin
        in_tready = 1'b1;
      end
      A_DECODE: begin
        scrolled_nxt = 1'b0;
        commit_nxt   = 1'b0;
        scr_re       = (op_r == OP_RD_SCREEN);
        lb_re        = (op_r == OP_RD_LINE);
      end
      A_CHAR: begin
        count_nxt = count_eff;
        if (key_r) begin
          pend_nxt = is_cr;
        end
        if (is_print) begin
          scr_we    = 1'b1;
          scr_waddr = cell_addr;
          scr_wdata = char_r;
          if (wrap) begin
            row_nxt = row_r + ROW_W'(1);
            col_nxt = '0;
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
          if (key_r && count_eff < LCW'(SCREEN_WIDTH)) begin
            lb_we     = 1'b1;
            count_nxt = count_eff + LCW'(1);
          end
        end else if (is_cr) begin
          commit_nxt = key_r;
        end else if (is_bs) begin
          if (bs_ok) begin
            col_nxt   = col_r - COL_W'(1);
            scr_we    = 1'b1;
            scr_waddr = cell_addr - CAW'(1);
            scr_wdata = CH_BLANK;
          end
          if (key_r && count_eff != '0) begin
            count_nxt = count_eff - LCW'(1);
          end
        end
      end
      A_NEWLINE: begin
        col_nxt = col_b;
        if (row_r >= last_row) begin
          scrolled_nxt = 1'b1;
          row_nxt      = last_row;
          ptr_nxt      = CAW'(b_eff) * CAW'(SCREEN_WIDTH);
          lim_nxt      = CAW'(last_row) * CAW'(SCREEN_WIDTH) - CAW'(1);
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end
      A_COPY_RD: begin
        scr_re    = 1'b1;
        scr_raddr = ptr_r + CAW'(SCREEN_WIDTH);
      end
      A_COPY_WR: begin
        scr_we    = 1'b1;
        scr_wdata = scr_rdata;
        ptr_nxt   = ptr_r + CAW'(1);
      end
      A_ROW_LIM: begin
        lim_nxt = lim_r + CAW'(SCREEN_WIDTH);
      end
      A_EMIT: begin
        if (!stall) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_CLEAR;
      border_r    <= 3'd1;
      row_r       <= ROW_W'(RST_B);
      col_r       <= COL_W'(RST_B);
      count_r     <= '0;
      pend_r      <= 1'b0;
      scrolled_r  <= 1'b0;
      commit_r    <= 1'b0;
      ptr_r       <= '0;
      lim_r       <= CAW'(CELLS - 1);
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      scrolled_r  <= scrolled_nxt;
      commit_r    <= commit_nxt;
      ptr_r       <= ptr_nxt;
      lim_r       <= lim_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        border_r <= cfg_data;
      end
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser[1:0];
      key_r  <= in_tuser[2];
      char_r <= in_tdata[7:0];
      addr_r <= in_tdata[18:8];
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (cw.act == A_EMIT && !stall) begin
      out_cursor_r   <= cur_x[10:0];
      out_len_r      <= 6'(count_r);
      out_data_r     <= read_val;
      out_scrolled_r <= scrolled_r;
      out_commit_r   <= commit_r;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_commit_r, out_scrolled_r, out_data_r, out_len_r, out_cursor_r};

`ifndef SYNTHESIS
  // Cursor row stays on screen whenever an item can be taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ST_IDLE) |-> (row_r < ROW_W'(SCREEN_HEIGHT)))
    else $error("cursor row off screen while idle");

  // Copy and row-clear sweeps never run past their limit
  assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ST_COPY_WR || pc_r == ST_ROW_CLR) |-> (ptr_r <= lim_r))
    else $error("sweep pointer past limit");

  // Line length never exceeds the screen width
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LCW'(SCREEN_WIDTH))
    else $error("line length overflow");

  // A completed emit step leaves a valid result word
  assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ST_EMIT && !stall) |=> (out_valid_r && pc_r == ST_IDLE))
    else $error("result word lost at emit");
`endif

endmodule

`default_nettype wire
